>>> sv/edist_pkg.sv
// Shared types and constants for the Euclidean distance unit.
// Used by the controller, the datapath and the top level.
package edist_pkg;

  localparam int COORD_W_DEF = 16;
  localparam int COORD_W_MAX = 32;
  localparam int SUM_W       = 48;
  localparam int DIST_W      = 24;
  localparam int SQ_IN_W     = SUM_W / 2;
  localparam int REM_W       = DIST_W + 1;
  localparam int ROOT_STEPS  = DIST_W;
  localparam int CNT_W       = $clog2(ROOT_STEPS);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_ROOT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic in_take;
    logic root_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_last;
    logic out_busy;
  } dp_sts_t;

endpackage

>>> sv/edist_ctrl.sv
// Sequencer for the Euclidean distance unit: input gating, root iterations, result load.
// Depends on edist_pkg; drives the datapath only through dp_cmd_t and dp_sts_t.
module edist_ctrl
  import edist_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    in_ready      = 1'b0;
    cmd.in_take   = 1'b0;
    cmd.root_step = 1'b0;
    cmd.out_load  = 1'b0;
    unique case (state)
      ST_RUN: begin
        in_ready    = 1'b1;
        cmd.in_take = in_valid;
        if (in_valid && in_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts.acc_last) begin
          state_next = ST_ROOT;
          count_next = '0;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        count_next    = count + 1'b1;
        if (count == CNT_W'(ROOT_STEPS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  a_last_in_flush: assert property (@(posedge clk) disable iff (rst)
    sts.acc_last |-> state == ST_FLUSH)
    else $error("final pair reached the accumulator outside flush");

  a_root_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROOT |-> count < CNT_W'(ROOT_STEPS))
    else $error("root iteration count out of range");

endmodule

>>> sv/edist_datapath.sv
// Datapath: difference and magnitude, registered square, saturating accumulator,
// bit-serial floor square root and output register. Depends on edist_pkg.
module edist_datapath
  import edist_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_W_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  input  logic [COORD_WIDTH-1:0] coord_a,
  input  logic [COORD_WIDTH-1:0] coord_b,
  input  logic                   last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DIST_W-1:0]      distance,
  output logic                   saturated
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int MAG_W = COORD_W_MAX + 1;

  logic signed [DW-1:0] diff;
  logic [DW-1:0]        mag;
  logic [MAG_W-1:0]     mag_ext;

  logic                 s1_vld, s1_last, s1_big;
  logic [SQ_IN_W-1:0]   s1_mag;
  logic                 s2_vld, s2_last, s2_big;
  logic [SUM_W-1:0]     s2_sq;

  logic [SUM_W-1:0]     sum;
  logic                 sum_sat;
  logic [SUM_W:0]       sum_wide;
  logic                 ovf;
  logic [SUM_W-1:0]     sum_next;
  logic                 sat_next;

  logic [SUM_W-1:0]     rad;
  logic [REM_W-1:0]     rem;
  logic [DIST_W-1:0]    root;
  logic                 root_sat;
  logic [REM_W+1:0]     rem_sh;
  logic [REM_W+1:0]     trial;
  logic                 fits;

  assign diff    = $signed({coord_a[COORD_WIDTH-1], coord_a})
                 - $signed({coord_b[COORD_WIDTH-1], coord_b});
  assign mag     = diff[DW-1] ? ~diff + 1'b1 : diff;
  assign mag_ext = MAG_W'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= cmd.in_take;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_last <= last;
    s1_big  <= |mag_ext[MAG_W-1:SQ_IN_W];
    s1_mag  <= mag_ext[SQ_IN_W-1:0];
    s2_last <= s1_last;
    s2_big  <= s1_big;
    s2_sq   <= s1_mag * s1_mag;
  end

  assign sum_wide = {1'b0, sum} + {1'b0, s2_sq};
  assign ovf      = s2_big | sum_wide[SUM_W];
  assign sum_next = ovf ? '1 : sum_wide[SUM_W-1:0];
  assign sat_next = sum_sat | ovf;

  assign sts.acc_last = s2_vld & s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum     <= '0;
      sum_sat <= 1'b0;
    end else if (s2_vld) begin
      if (s2_last) begin
        sum     <= '0;
        sum_sat <= 1'b0;
      end else begin
        sum     <= sum_next;
        sum_sat <= sat_next;
      end
    end
  end

  assign rem_sh = {rem, rad[SUM_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (sts.acc_last) begin
      rad      <= sum_next;
      root_sat <= sat_next;
      rem      <= '0;
      root     <= '0;
    end else if (cmd.root_step) begin
      rad  <= {rad[SUM_W-3:0], 2'b00};
      rem  <= fits ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
      root <= {root[DIST_W-2:0], fits};
    end
  end

  assign sts.out_busy = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      distance  <= root;
      saturated <= root_sat;
    end
  end

  a_pipe_keep: assert property (@(posedge clk) disable iff (rst)
    s1_vld |=> s2_vld)
    else $error("pair lost between magnitude and square stages");

  a_sum_clear: assert property (@(posedge clk) disable iff (rst)
    sts.acc_last |=> (sum == '0) && !sum_sat)
    else $error("sum not cleared after final pair");

  a_nothing_behind_last: assert property (@(posedge clk) disable iff (rst)
    sts.acc_last |-> !s1_vld)
    else $error("pair accepted behind the final pair");

endmodule

>>> sv/euclidean_distance_unit.sv
// Euclidean distance unit: streams coordinate pairs, sums saturating squared differences,
// and returns the floor square root per vector. Depends on edist_pkg, edist_ctrl and
// edist_datapath.
//
// Coordinate pairs are taken one per cycle while a vector streams in. The pair marked
// tlast holds off further input while it passes through the square pipeline, while the
// bit-serial square root runs (one result bit per cycle), and while the result register
// is loaded, longer if that register is still waiting to be taken. The result register
// lets the next vector stream in while a distance waits downstream.
module euclidean_distance_unit
  import edist_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_W_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // coord_a, coord_b, zero pad to whole bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  input  logic                                     s_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // distance
  output logic [DIST_W-1:0]                        m_axis_tdata,
  // saturated
  output logic                                     m_axis_tuser
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  edist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  edist_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .coord_a   (s_axis_tdata[COORD_WIDTH-1:0]),
    .coord_b   (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .last      (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .distance  (m_axis_tdata),
    .saturated (m_axis_tuser)
  );

endmodule

>>> bench/testbench.sv
// Testbench for euclidean_distance_unit: streams coordinate pairs, predicts each distance
// with a saturating sum of squares and a floor square root, and checks every result.
// Depends on edist_pkg and the euclidean_distance_unit RTL.

typedef struct {
  logic [edist_pkg::DIST_W-1:0] distance;
  logic                         saturated;
} distance_result_t;

class distance_scoreboard;
  localparam logic [47:0] SUM_CEILING = {48{1'b1}};

  logic [47:0]      running_sum;
  logic             running_sat;
  distance_result_t pending_distances[$];
  int               mismatches;
  int               requests_taken;

  function new();
    running_sum    = '0;
    running_sat    = 1'b0;
    mismatches     = 0;
    requests_taken = 0;
  endfunction

  function logic [23:0] floor_root(logic [47:0] value);
    logic [23:0] root;
    logic [47:0] trial;
    root = '0;
    for (int i = 23; i >= 0; i--) begin
      trial = {24'd0, root | (24'd1 << i)};
      if (trial * trial <= value) root = trial[23:0];
    end
    return root;
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function void note_pair(logic signed [15:0] coord_a, logic signed [15:0] coord_b,
                          logic last);
    logic signed [16:0] diff;
    logic        [15:0] magnitude;
    logic        [47:0] square;
    logic        [48:0] total;
    distance_result_t   res;
    diff      = 17'(coord_a) - 17'(coord_b);
    magnitude = diff[16] ? 16'(-diff) : diff[15:0];
    square    = 48'(magnitude) * 48'(magnitude);
    total     = 49'(running_sum) + 49'(square);
    if (total[48]) begin
      running_sum = SUM_CEILING;
      running_sat = 1'b1;
    end else begin
      running_sum = total[47:0];
    end
    requests_taken++;
    if (last) begin
      res.distance  = floor_root(running_sum);
      res.saturated = running_sat;
      pending_distances = {pending_distances, res};
      running_sum = '0;
      running_sat = 1'b0;
    end
  endfunction

  task check_distance(logic [edist_pkg::DIST_W-1:0] distance, logic saturated);
    distance_result_t want;
    if (pending_distances.size() == 0) begin
      report($sformatf("unexpected result distance=%0d saturated=%0b", distance, saturated));
    end else begin
      want = pending_distances.pop_front();
      if (distance !== want.distance)
        report($sformatf("distance got %0d want %0d", distance, want.distance));
      if (saturated !== want.saturated)
        report($sformatf("saturated got %0b want %0b", saturated, want.saturated));
    end
  endtask

  function int outstanding();
    return pending_distances.size();
  endfunction
endclass

module testbench
  import edist_pkg::*;
();

  localparam int ITEM_TARGET = 1750;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DIST_W-1:0] m_axis_tdata;
  logic              m_axis_tuser;

  distance_scoreboard sb = new();
  bit                 src_calm  = 1'b0;
  bit                 sink_calm = 1'b0;
  int                 sink_hold = 0;
  int                 cycles    = 0;

  euclidean_distance_unit #(.COORD_WIDTH(16)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 32)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pair(logic [15:0] coord_a, logic [15:0] coord_b, logic last);
    int gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {coord_b, coord_a};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_pair(coord_a, coord_b, last);
  endtask

  task automatic send_vector(int length);
    for (int i = 0; i < length; i++) send_pair(pick_coord(), pick_coord(), i == length - 1);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("euclidean_distance_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_distance(m_axis_tdata, m_axis_tuser);
    if (sink_hold > 0) sink_hold = sink_hold - 1;
    else sink_hold = pick_gap(sink_calm);
    m_axis_tready <= (sink_hold == 0);
  end

  initial begin
    int length;
    int r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'h7fff, 16'h8000, 1'b1);
    send_pair(16'h8000, 16'h7fff, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'h7fff, 16'h7fff, 1'b1);
    send_pair(16'h0001, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'hffff, 1'b1);
    send_pair(16'h1000, 16'h0000, 1'b1);
    send_pair(16'h3000, 16'h1000, 1'b0);
    send_pair(16'hf000, 16'h0000, 1'b1);
    send_pair(16'h0003, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h0004, 1'b0);
    send_pair(16'h5555, 16'haaaa, 1'b1);

    while (sb.requests_taken < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 70) length = $urandom_range(1, 8);
      else if (r < 95) length = $urandom_range(9, 40);
      else length = $urandom_range(41, 200);
      src_calm  = ($urandom_range(0, 99) < 15);
      sink_calm = ($urandom_range(0, 99) < 15);
      send_vector(length);
    end
    s_axis_tvalid <= 1'b0;
    sink_calm = 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0) sb.report("expected distances left over");
    if (sb.mismatches == 0) begin
      $display("euclidean_distance_unit verification clean");
    end else begin
      $display("euclidean_distance_unit verification failed");
    end
    $finish;
  end
endmodule
